>>> rtl/cct_pkg.sv
// Package for the column change trigger: controller/datapath command and
// status structs, state encoding, register indexes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package cct_pkg;

    // Fixed field widths.
    localparam int PIX_W       = 8;
    localparam int TS_W        = 32;
    localparam int SUM_W       = 23;
    localparam int COUNT_W     = 11;
    localparam int THRESH_W    = 13;
    localparam int WINDOW_W    = 16;
    localparam int WIDTH_W     = 13;
    localparam int COL_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int D2_W        = 18;
    localparam int DIST_INT_W  = 9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARMED          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_WIDTH    = 2'd3;

    // Reset values and limits.
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd500;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 13'd2;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = 13'd4096;
    localparam logic [SUM_W-1:0]    SUM_MAX      = 23'h7FFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_START,
        ST_ROOT,
        ST_STORE,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic ready;       // input channel may transfer
        logic accept;      // an input transfer happens this cycle
        logic ram_rd;      // read the previous column entry of this row
        logic load_d2;     // register the squared distance
        logic sqrt_start;  // launch the square root
        logic store;       // write the pixel back and advance the row
        logic add_dist;    // add the distance to the running sum
        logic load_prod;   // register threshold times row count
        logic finish;      // load the result and close the strip
    } t_cmd;

    typedef struct packed {
        logic take;        // the offered pixel is a middle-column pixel to use
        logic have_prev;   // a previous strip exists
        logic in_last;     // the offered pixel ends the strip
        logic item_last;   // the pixel in work ends the strip
        logic sqrt_done;   // square root result is ready
        logic out_free;    // output register can take a result
    } t_stat;

endpackage

>>> rtl/cct_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read.
// No dependencies.
`timescale 1ns / 1ps

module cct_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cct_isqrt.sv
// Iterative integer square root, one result bit per cycle (floor of the root).
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module cct_isqrt #(
    parameter int QW = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2*QW-1:0]  i_radicand,
    output logic [QW-1:0]    o_root,
    output logic             o_done
);
    localparam int RW  = 2 * QW;
    localparam int RMW = QW + 3;
    localparam int CNW = $clog2(QW + 1);
    localparam logic [CNW-1:0] LAST_STEP = CNW'(QW - 1);

    logic [RW-1:0]  r_rad;
    logic [RMW-1:0] r_rem;
    logic [QW-1:0]  r_root;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [RMW-1:0] w_shifted;
    logic [RMW-1:0] w_trial;
    logic           w_fit;

    // Bring down the next two radicand bits and try appending a one bit.
    assign w_shifted = {r_rem[RMW-3:0], r_rad[RW-1 -: 2]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_fit     = (w_shifted >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_fit ? (w_shifted - w_trial) : w_shifted;
            r_root <= {r_root[QW-2:0], w_fit};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == LAST_STEP)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

>>> rtl/cct_ctrl.sv
// Controller state machine of the column change trigger.
// Depends on cct_pkg for the state, command and status types.
`timescale 1ns / 1ps

module cct_ctrl import cct_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_stat.take) begin
                        n_state = i_stat.have_prev ? ST_READ : ST_STORE;
                    end else if (i_stat.in_last) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_READ:   n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_START;
            ST_START:  n_state = ST_ROOT;
            ST_ROOT: begin
                if (i_stat.sqrt_done) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE:  n_state = i_stat.item_last ? ST_MUL : ST_IDLE;
            ST_MUL:    n_state = ST_FIN;
            ST_FIN: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_READ:   o_cmd.ram_rd = 1'b1;
            ST_SQUARE: o_cmd.load_d2 = 1'b1;
            ST_START:  o_cmd.sqrt_start = 1'b1;
            ST_ROOT:   o_cmd = '0;
            ST_STORE: begin
                o_cmd.store    = 1'b1;
                o_cmd.add_dist = i_stat.have_prev;
            end
            ST_MUL:    o_cmd.load_prod = 1'b1;
            ST_FIN:    o_cmd.finish = i_stat.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/cct_dp.sv
// Datapath of the column change trigger: configuration registers, column and
// row tracking, previous-column RAM, distance, sum, trigger test, output register.
// Depends on cct_pkg, cct_ram and cct_isqrt.
`timescale 1ns / 1ps

module cct_dp import cct_pkg::*; #(
    parameter int MAX_ROWS      = 1024,
    parameter int FRACTION_BITS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [PIX_W-1:0]       i_red,
    input  logic [PIX_W-1:0]       i_green,
    input  logic [PIX_W-1:0]       i_blue,
    input  logic                   i_last,
    input  logic [TS_W-1:0]        i_ts,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_triggered,
    output logic                   o_in_window,
    output logic [SUM_W-1:0]       o_error_sum,
    output logic [COUNT_W-1:0]     o_row_count
);
    localparam int CW  = $clog2(MAX_ROWS + 1);
    localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QW  = DIST_INT_W + FRACTION_BITS;
    localparam int RW  = 2 * QW;
    localparam int PW  = THRESH_W + CW;
    localparam int PIXEL_W = 3 * PIX_W;
    localparam logic [CW-1:0] ROW_LIMIT = CW'(MAX_ROWS);

    // Configuration.
    logic [THRESH_W-1:0] r_threshold;
    logic                r_armed;
    logic [WINDOW_W-1:0] r_window;
    logic [WIDTH_W-1:0]  r_width;

    // Strip state.
    logic [COL_W-1:0]    r_col;
    logic [CW-1:0]       r_row;
    logic [SUM_W-1:0]    r_sum;
    logic                r_have_prev;
    logic [TS_W-1:0]     r_last_trig;

    // Pixel in work.
    logic [PIX_W-1:0]    r_red;
    logic [PIX_W-1:0]    r_green;
    logic [PIX_W-1:0]    r_blue;
    logic                r_last;
    logic [TS_W-1:0]     r_ts;

    logic [D2_W-1:0]     r_d2;
    logic [PW-1:0]       r_prod;

    // Output register.
    logic                r_out_valid;
    logic                r_out_trig;
    logic                r_out_win;
    logic [SUM_W-1:0]    r_out_sum;
    logic [COUNT_W-1:0]  r_out_count;

    logic [WIDTH_W-1:0]  w_width;
    logic [WIDTH_W-1:0]  w_mid;
    logic [WIDTH_W-1:0]  w_col_inc;
    logic [PIXEL_W-1:0]  w_prev_pix;
    logic [PIX_W-1:0]    w_dr;
    logic [PIX_W-1:0]    w_dg;
    logic [PIX_W-1:0]    w_db;
    logic [2*PIX_W-1:0]  w_sq_r;
    logic [2*PIX_W-1:0]  w_sq_g;
    logic [2*PIX_W-1:0]  w_sq_b;
    logic [D2_W-1:0]     w_d2;
    logic [QW-1:0]       w_root;
    logic                w_root_done;
    logic [SUM_W:0]      w_sum_add;
    logic                w_trig;
    logic                w_in_win;
    logic                w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_armed     <= 1'b0;
            r_window    <= WINDOW_RESET;
            r_width     <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESHOLD:      r_threshold <= i_cfg_data[THRESH_W-1:0];
                REG_ARMED:          r_armed     <= i_cfg_data[0];
                REG_DISCARD_WINDOW: r_window    <= i_cfg_data[WINDOW_W-1:0];
                REG_STRIP_WIDTH:    r_width     <= i_cfg_data[WIDTH_W-1:0];
                default:            r_armed     <= r_armed;
            endcase
        end
    end

    assign w_width   = (r_width < WIDTH_MIN) ? WIDTH_MIN :
                       ((r_width > WIDTH_MAX) ? WIDTH_MAX : r_width);
    assign w_mid     = w_width >> 1;
    assign w_col_inc = {1'b0, r_col} + 1'b1;

    assign o_stat.take      = ({1'b0, r_col} == w_mid) && (r_row < ROW_LIMIT);
    assign o_stat.have_prev = r_have_prev;
    assign o_stat.in_last   = i_last;
    assign o_stat.item_last = r_last;
    assign o_stat.sqrt_done = w_root_done;
    assign o_stat.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_last  <= i_last;
            r_ts    <= i_ts;
        end
        if (i_cmd.load_d2) begin
            r_d2 <= w_d2;
        end
        if (i_cmd.load_prod) begin
            r_prod <= PW'(r_threshold) * PW'(r_row);
        end
    end

    // Strip bookkeeping. The column restarts at zero after the final pixel or at the strip width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_sum       <= '0;
            r_have_prev <= 1'b0;
            r_last_trig <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (i_last || (w_col_inc >= w_width)) begin
                    r_col <= '0;
                end else begin
                    r_col <= w_col_inc[COL_W-1:0];
                end
            end
            if (i_cmd.store) begin
                r_row <= r_row + 1'b1;
            end
            if (i_cmd.add_dist) begin
                r_sum <= w_sum_add[SUM_W] ? SUM_MAX : w_sum_add[SUM_W-1:0];
            end
            if (i_cmd.finish) begin
                r_row       <= '0;
                r_sum       <= '0;
                r_have_prev <= 1'b1;
                if (w_trig) begin
                    r_last_trig <= r_ts;
                end
            end
        end
    end

    cct_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_ROWS)
    ) u_prev_col (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_row[AW-1:0]),
        .i_wdata ({r_red, r_green, r_blue}),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_row[AW-1:0]),
        .o_rdata (w_prev_pix)
    );

    always_comb begin
        w_dr = (r_red > w_prev_pix[3*PIX_W-1 -: PIX_W]) ?
               r_red - w_prev_pix[3*PIX_W-1 -: PIX_W] :
               w_prev_pix[3*PIX_W-1 -: PIX_W] - r_red;
        w_dg = (r_green > w_prev_pix[2*PIX_W-1 -: PIX_W]) ?
               r_green - w_prev_pix[2*PIX_W-1 -: PIX_W] :
               w_prev_pix[2*PIX_W-1 -: PIX_W] - r_green;
        w_db = (r_blue > w_prev_pix[PIX_W-1:0]) ?
               r_blue - w_prev_pix[PIX_W-1:0] :
               w_prev_pix[PIX_W-1:0] - r_blue;
        w_sq_r = (2*PIX_W)'(w_dr) * (2*PIX_W)'(w_dr);
        w_sq_g = (2*PIX_W)'(w_dg) * (2*PIX_W)'(w_dg);
        w_sq_b = (2*PIX_W)'(w_db) * (2*PIX_W)'(w_db);
        w_d2   = D2_W'(w_sq_r) + D2_W'(w_sq_g) + D2_W'(w_sq_b);
    end

    // The fraction bits come from scaling the squared distance by 4^FRACTION_BITS.
    cct_isqrt #(
        .QW (QW)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (RW'(r_d2) << (2 * FRACTION_BITS)),
        .o_root     (w_root),
        .o_done     (w_root_done)
    );

    assign w_sum_add = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(w_root);

    assign w_trig   = r_armed && r_have_prev && (32'(r_sum) > 32'(r_prod));
    assign w_in_win = (r_ts - r_last_trig) < TS_W'(r_window);

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_trig  <= w_trig;
            r_out_win   <= w_in_win;
            r_out_sum   <= r_sum;
            r_out_count <= COUNT_W'(r_row);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_triggered = r_out_trig;
    assign o_in_window = r_out_win;
    assign o_error_sum = r_out_sum;
    assign o_row_count = r_out_count;

endmodule

>>> rtl/column_change_trigger_unit.sv
// Top level of the column change trigger: controller plus datapath.
// Depends on cct_pkg, cct_ctrl and cct_dp (which holds cct_ram and cct_isqrt).
//
//  Channel    Direction  Handshake                    Contents
//  s_axis     in         s_axis_tvalid/s_axis_tready  one raster pixel, tlast ends strip
//  m_axis     out        m_axis_tvalid/m_axis_tready  one strip result
//  cfg        in         i_cfg_we                     register write, no back-pressure
//
// A pixel outside the middle column is taken in the idle state. A middle-column pixel
// passes the store state on the first strip and afterwards the read, square, start,
// root (waiting on the one-bit-per-cycle square root unit) and store states. The
// final pixel adds the threshold product and result load, held while the output is full.
// Reset is synchronous and active low; the previous-column RAM is not cleared.
`timescale 1ns / 1ps

module column_change_trigger_unit import cct_pkg::*; #(
    parameter int MAX_ROWS      = 1024,
    parameter int FRACTION_BITS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [55:0]            s_axis_tdata,   // red, green, blue, timestamp_ms
    input  logic                   s_axis_tlast,   // last_pixel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [39:0]            m_axis_tdata,   // error_sum, row_count, zero pad
    output logic [1:0]             m_axis_tuser,   // triggered, in_window
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    t_cmd               w_cmd;
    t_stat              w_stat;
    logic               w_triggered;
    logic               w_in_window;
    logic [SUM_W-1:0]   w_error_sum;
    logic [COUNT_W-1:0] w_row_count;

    cct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    cct_dp #(
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_red       (s_axis_tdata[7:0]),
        .i_green     (s_axis_tdata[15:8]),
        .i_blue      (s_axis_tdata[23:16]),
        .i_last      (s_axis_tlast),
        .i_ts        (s_axis_tdata[55:24]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_triggered (w_triggered),
        .o_in_window (w_in_window),
        .o_error_sum (w_error_sum),
        .o_row_count (w_row_count)
    );

    assign s_axis_tready = w_cmd.ready;
    assign m_axis_tdata  = {6'b0, w_row_count, w_error_sum};
    assign m_axis_tuser  = {w_in_window, w_triggered};

endmodule

>>> tb/strip_result_checker.sv
// Checker for the column change trigger: watches the pixel, result and register
// channels, predicts each strip result and compares it field by field.
// Depends on cct_pkg for field widths, register indexes and reset values.
`timescale 1ns / 1ps

module strip_result_checker import cct_pkg::*; #(
    parameter int MAX_ROWS      = 1024,
    parameter int FRACTION_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [55:0]           s_axis_tdata,   // red, green, blue, timestamp_ms
    input  logic                  s_axis_tlast,   // last_pixel
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [39:0]           m_axis_tdata,   // error_sum, row_count, zero pad
    input  logic [1:0]            m_axis_tuser,   // triggered, in_window
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [31:0]           o_errors,
    output logic [31:0]           o_pending
);

    typedef struct packed {
        logic               triggered;
        logic               in_window;
        logic [SUM_W-1:0]   error_sum;
        logic [COUNT_W-1:0] row_count;
    } t_strip_result;

    t_strip_result expected_strips[$];

    // Register copies.
    logic [THRESH_W-1:0] threshold;
    logic                armed;
    logic [WINDOW_W-1:0] discard_window;
    logic [WIDTH_W-1:0]  strip_width;

    // Strip state.
    logic [23:0]      column_mem [MAX_ROWS];
    logic             have_prev;
    int               col_pos;
    int               row_pos;
    logic [SUM_W-1:0] dist_sum;
    logic [TS_W-1:0]  last_trigger;

    int fail_total = 0;
    int waiting = 0;

    assign o_errors  = fail_total;
    assign o_pending = waiting;

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            t = r | (64'd1 << k);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        fail_total++;
    endtask

    task automatic absorb_pixel(input logic [55:0] data, input logic last);
        logic [23:0]     px;
        logic [TS_W-1:0] ts;
        logic [TS_W-1:0] delta;
        int              w;
        int              d2;
        int              diff;
        longint unsigned total;
        t_strip_result   res;
        px = data[23:0];
        ts = data[55:24];
        w  = int'(strip_width);
        if (w < int'(WIDTH_MIN)) w = int'(WIDTH_MIN);
        if (w > int'(WIDTH_MAX)) w = int'(WIDTH_MAX);

        if (col_pos == w / 2 && row_pos < MAX_ROWS) begin
            if (have_prev) begin
                d2 = 0;
                for (int k = 0; k < 3; k++) begin
                    diff = int'(px[8*k +: 8]) - int'(column_mem[row_pos][8*k +: 8]);
                    d2 += diff * diff;
                end
                total = longint'(dist_sum)
                      + floor_root(longint'(d2) << (2 * FRACTION_BITS));
                dist_sum = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
            end
            column_mem[row_pos] = px;
            row_pos++;
        end

        col_pos++;
        if (col_pos >= w) col_pos = 0;

        if (last) begin
            delta = ts - last_trigger;
            res.row_count = COUNT_W'(row_pos);
            res.error_sum = dist_sum;
            res.in_window = delta < {16'd0, discard_window};
            res.triggered = armed && have_prev &&
                            (longint'(dist_sum) > longint'(threshold) * longint'(row_pos));
            if (res.triggered) last_trigger = ts;
            expected_strips.insert(expected_strips.size(), res);
            have_prev = 1'b1;
            col_pos   = 0;
            row_pos   = 0;
            dist_sum  = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_strip_result want;
        if (!i_rst_n) begin
            threshold      = '0;
            armed          = 1'b0;
            discard_window = WINDOW_RESET;
            strip_width    = WIDTH_RESET;
            have_prev      = 1'b0;
            col_pos        = 0;
            row_pos        = 0;
            dist_sum       = '0;
            last_trigger   = '0;
            expected_strips.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_strips.size() == 0) begin
                    report_mismatch("unrequested strip result, error_sum",
                                    m_axis_tdata[SUM_W-1:0], 0);
                end else begin
                    want = expected_strips.pop_front();
                    if (m_axis_tdata[SUM_W-1:0] !== want.error_sum)
                        report_mismatch("error_sum", m_axis_tdata[SUM_W-1:0], want.error_sum);
                    if (m_axis_tdata[SUM_W +: COUNT_W] !== want.row_count)
                        report_mismatch("row_count", m_axis_tdata[SUM_W +: COUNT_W],
                                        want.row_count);
                    if (m_axis_tuser[0] !== want.triggered)
                        report_mismatch("triggered", m_axis_tuser[0], want.triggered);
                    if (m_axis_tuser[1] !== want.in_window)
                        report_mismatch("in_window", m_axis_tuser[1], want.in_window);
                end
            end
            if (s_axis_tvalid && s_axis_tready) absorb_pixel(s_axis_tdata, s_axis_tlast);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_THRESHOLD:      threshold      = i_cfg_data[THRESH_W-1:0];
                    REG_ARMED:          armed          = i_cfg_data[0];
                    REG_DISCARD_WINDOW: discard_window = i_cfg_data[WINDOW_W-1:0];
                    REG_STRIP_WIDTH:    strip_width    = i_cfg_data[WIDTH_W-1:0];
                    default: ;
                endcase
            end
        end
        waiting = expected_strips.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the column change trigger testbench: clock, reset, pixel strips,
// register writes, output back-pressure and the final verdict.
// Depends on cct_pkg, column_change_trigger_unit and strip_result_checker.
`timescale 1ns / 1ps

module testbench import cct_pkg::*;;

    localparam int MAX_ROWS      = 1024;
    localparam int FRACTION_BITS = 4;

    typedef enum {FILL_SOLID, FILL_SCENE, FILL_NOISE} t_fill;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [31:0] fail_total;
    logic [31:0] results_waiting;

    int          send_idle = 26;
    int          recv_idle = 72;
    int          width_eff = 640;
    logic [31:0] clock_ms  = 32'd1000;
    logic [23:0] scene [MAX_ROWS];
    int          amps [7]  = '{0, 1, 3, 8, 20, 60, 255};

    column_change_trigger_unit #(
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    strip_result_checker #(
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (fail_total),
        .o_pending     (results_waiting)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [23:0] shade(input logic [23:0] base, input int amp);
        logic [23:0] px;
        int          v;
        for (int k = 0; k < 3; k++) begin
            v = int'(base[8*k +: 8]) + int'($urandom_range(0, 2 * amp)) - amp;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            px[8*k +: 8] = 8'(v);
        end
        return px;
    endfunction

    // Mostly small steps so the discard window matters, now and then a jump.
    function automatic logic [31:0] next_stamp();
        if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 800);
        return clock_ms;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == REG_STRIP_WIDTH) begin
            width_eff = int'(value[WIDTH_W-1:0]);
            if (width_eff < int'(WIDTH_MIN)) width_eff = int'(WIDTH_MIN);
            if (width_eff > int'(WIDTH_MAX)) width_eff = int'(WIDTH_MAX);
        end
    endtask

    // Middle-column pixels keep the block busy after their transfer, so a
    // margin follows the last result before registers change.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (results_waiting != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic push_pixel(input logic [23:0] px, input logic last, input logic [31:0] ts);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {ts, px};
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_strip(input int count, input t_fill fill, input logic [23:0] color,
                              input int amp, input logic [31:0] last_ts);
        logic [23:0] px;
        int          row;
        for (int i = 0; i < count; i++) begin
            row = (i / width_eff) % MAX_ROWS;
            case (fill)
                FILL_SOLID: px = color;
                FILL_SCENE: px = shade(scene[row], amp);
                default:    px = 24'($urandom);
            endcase
            push_pixel(px, i == count - 1, (i == count - 1) ? last_ts : $urandom);
        end
    endtask

    initial begin
        int          sent;
        int          n;
        int          rows;
        int          pick;
        t_fill       fill;
        logic [23:0] color;
        int          leftover;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        foreach (scene[k]) scene[k] = 24'($urandom);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The first strip stores more rows than any later strip reaches, so no
        // strip compares against a row that was never written. Width 1 acts as 2.
        cfg_write(REG_STRIP_WIDTH, 16'd1);
        send_strip(32, FILL_SCENE, '0, 0, 32'd0);
        settle();

        // Threshold 0 while armed: an unchanged column must not trigger.
        cfg_write(REG_ARMED, 16'd1);
        send_strip(8, FILL_SCENE, '0, 0, 32'd100);
        send_strip(8, FILL_SOLID, 24'hFFFFFF, 0, 32'hFFFF_FFFF);
        // Full swing back to black, timestamp wrapping just past the trigger.
        send_strip(8, FILL_SOLID, 24'h000000, 0, 32'd3);
        // A single pixel never reaches the middle column.
        send_strip(1, FILL_SOLID, 24'h00FF80, 0, 32'd10);
        send_strip(3, FILL_SOLID, 24'h80FF00, 0, 32'd20);
        settle();

        cfg_write(REG_THRESHOLD, 16'hFFFF);
        cfg_write(REG_DISCARD_WINDOW, 16'd0);
        send_strip(4, FILL_NOISE, '0, 0, 32'd30);
        settle();

        cfg_write(REG_THRESHOLD, 16'd1);
        cfg_write(REG_ARMED, 16'hFFFE);
        cfg_write(REG_DISCARD_WINDOW, 16'hFFFF);
        send_strip(4, FILL_NOISE, '0, 0, 32'd40);
        settle();

        // A width past the limit; a short strip never reaches its middle.
        cfg_write(REG_ARMED, 16'd1);
        cfg_write(REG_STRIP_WIDTH, 16'hFFFF);
        send_strip(40, FILL_NOISE, '0, 0, 32'd50);

        for (int seg = 0; seg < 12; seg++) begin
            settle();
            if (seg == 4) begin
                send_idle = 72;
                recv_idle = 26;
            end else if (seg == 8) begin
                send_idle = 0;
                recv_idle = 0;
            end
            pick = $urandom_range(0, 5);
            cfg_write(REG_THRESHOLD, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                                     (pick == 2) ? 16'($urandom) :
                                     16'($urandom_range(0, 2500)));
            cfg_write(REG_ARMED, {15'($urandom), ($urandom_range(0, 3) != 0)});
            pick = $urandom_range(0, 3);
            cfg_write(REG_DISCARD_WINDOW, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                                          (pick == 2) ? 16'd500 : 16'($urandom));
            cfg_write(REG_STRIP_WIDTH, ($urandom_range(0, 7) == 0) ?
                                       16'($urandom_range(25, 200)) :
                                       16'($urandom_range(0, 24)));
            sent = 0;
            while (sent < 85) begin
                rows = (width_eff > 24) ? $urandom_range(0, 1) : $urandom_range(0, 3);
                n = rows * width_eff + $urandom_range(0, width_eff - 1);
                if (n == 0) n = 1;
                pick  = $urandom_range(0, 5);
                fill  = (pick == 0) ? FILL_NOISE : (pick == 1) ? FILL_SOLID : FILL_SCENE;
                color = 24'($urandom);
                send_strip(n, fill, color, amps[$urandom_range(0, 6)], next_stamp());
                sent += n;
            end
        end

        s_axis_tvalid = 1'b0;
        for (n = 0; n < 200000 && results_waiting != 0; n++) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        leftover = results_waiting;
        if (fail_total == 0 && leftover == 0) begin
            $display("RESULT: OK");
        end else begin
            if (leftover != 0) $display("%0d strip results never arrived", leftover);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
